>>> rtl/tsom_pkg.sv
package tsom_pkg;

	// stack sizes and stored word width
	localparam int X_DEPTH     = 8;
	localparam int Y_DEPTH     = 8;
	localparam int WORD_WIDTH  = 32;
	localparam int STORE_DEPTH = X_DEPTH + Y_DEPTH;

	// derived widths
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int XF_W   = $clog2(X_DEPTH + 1);
	localparam int YF_W   = $clog2(Y_DEPTH + 1);
	localparam int CNT_W  = (XF_W > YF_W) ? XF_W : YF_W;

	// port field widths
	localparam int OP_W     = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int IN_W     = ((OP_W + VAL_W + 7) / 8) * 8;
	localparam int OUT_W    = ((STATUS_W + VAL_W + 7) / 8) * 8;

	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [XF_W-1:0]       xfill_t;
	typedef logic [YF_W-1:0]       yfill_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [WORD_WIDTH-1:0] mem_word_t;
	typedef logic [OP_W-1:0]       op_t;
	typedef logic [STATUS_W-1:0]   status_t;

	// opcodes
	localparam op_t OP_PUSH_X = 3'd0;
	localparam op_t OP_PUSH_Y = 3'd1;
	localparam op_t OP_POP_X  = 3'd2;
	localparam op_t OP_POP_Y  = 3'd3;
	localparam op_t OP_SHOW_X = 3'd4;
	localparam op_t OP_SHOW_Y = 3'd5;

	// result status codes
	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;
	localparam status_t ST_EMPTY     = 2'd3;

	// memory access from the sequencer
	typedef struct packed {
		logic      we;
		addr_t     waddr;
		mem_word_t wdata;
		logic      re;
		addr_t     raddr;
	} ram_req_t;

	// result load into the output register
	typedef struct packed {
		logic    load;
		logic    from_ram;
		status_t status;
		logic    last;
	} res_t;

	// low stored bits of a sign-extended 32-bit value
	function automatic mem_word_t word_in(input logic [VAL_W-1:0] v);
		logic signed [63:0] e;
		e = 64'($signed(v));
		return e[WORD_WIDTH-1:0];
	endfunction

	// stored word sign-extended, fitted to 32 bits
	function automatic logic [VAL_W-1:0] word_out(input mem_word_t w);
		logic signed [63:0] e;
		e = 64'($signed(w));
		return e[VAL_W-1:0];
	endfunction

endpackage

>>> rtl/two_stacks_one_memory_unit.sv
// Two stacks held in one 16-word memory: stack X fills upward from entry 0, stack Y
// downward from the last entry, 8 words each. A request's opcode (s_tdata[2:0]) picks
// push, pop or show on X or Y; push_value (s_tdata[34:3]) is stored on a push. Each
// request returns one response (status ok, overflow, underflow or empty, with a word),
// except a show of a non-empty stack, which returns every word from top to base with
// tlast on the final one; opcodes six and seven are taken and answered with nothing.
// A push, an ignored opcode or an error answer is settled when it is taken; a pop waits
// for one memory read and a show for one read per word, and a stalled output holds them.
// The pacing is set by the single registered read port of the memory feeding a one-deep
// output register: a show first loads the walk, each word read waits for the registered
// read of the memory, and the next request is taken once the last read has landed in the
// output register.
module two_stacks_one_memory_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tsom_pkg::IN_W-1:0]   s_tdata,  // opcode[2:0], push_value[34:3]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tsom_pkg::OUT_W-1:0]  m_tdata,  // status[1:0], word[33:2]
	output logic                        m_tlast
);

	tsom_pkg::ram_req_t  ram_req;
	tsom_pkg::res_t      res;
	tsom_pkg::mem_word_t rdata;

	logic                         m_tvalid_q;
	tsom_pkg::status_t            status_q;
	logic [tsom_pkg::VAL_W-1:0]   word_q;
	logic                         last_q;
	logic                         out_free;

	assign out_free = !m_tvalid_q || m_tready;

	// request sequencing and stack pointers
	tsom_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.op         (s_tdata[tsom_pkg::OP_W-1:0]),
		.push_value (s_tdata[tsom_pkg::OP_W +: tsom_pkg::VAL_W]),
		.out_free   (out_free),
		.ram_req    (ram_req),
		.res        (res)
	);

	// shared stack memory
	tsom_ram #(
		.WIDTH (tsom_pkg::WORD_WIDTH),
		.DEPTH (tsom_pkg::STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q <= res.status;
			last_q   <= res.last;
			word_q   <= res.from_ram ? tsom_pkg::word_out(rdata) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = tsom_pkg::OUT_W'({word_q, status_q});

endmodule

>>> rtl/tsom_ram.sv
module tsom_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/tsom_seq.sv
module tsom_seq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  tsom_pkg::op_t          op,
	input  logic [tsom_pkg::VAL_W-1:0] push_value,
	input  logic                   out_free,
	output tsom_pkg::ram_req_t     ram_req,
	output tsom_pkg::res_t         res
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_SHOW = 2'b10
	} state_t;

	localparam tsom_pkg::addr_t ADDR_LAST = tsom_pkg::addr_t'(tsom_pkg::STORE_DEPTH - 1);

	state_t               state_q;
	tsom_pkg::xfill_t     x_fill_q;
	tsom_pkg::yfill_t     y_fill_q;
	tsom_pkg::cnt_t       cnt_q;
	tsom_pkg::addr_t      addr_q;
	logic                 up_q;
	logic                 rd_s1;
	logic                 last_s1;

	logic accept;
	logic x_full, y_full, x_empty, y_empty;
	logic show_issue;

	assign x_full  = (x_fill_q == tsom_pkg::xfill_t'(tsom_pkg::X_DEPTH));
	assign y_full  = (y_fill_q == tsom_pkg::yfill_t'(tsom_pkg::Y_DEPTH));
	assign x_empty = (x_fill_q == '0);
	assign y_empty = (y_fill_q == '0);

	// one item at a time, and only with room for its first result
	assign req_ready  = (state_q == S_IDLE) && !rd_s1 && out_free;
	assign accept     = req_valid && req_ready;
	assign show_issue = (state_q == S_SHOW) && !rd_s1 && out_free;

	// memory access and immediate results
	always_comb begin
		ram_req       = '0;
		ram_req.wdata = tsom_pkg::word_in(push_value);
		res           = '0;
		if (rd_s1) begin
			res.load     = 1'b1;
			res.from_ram = 1'b1;
			res.status   = tsom_pkg::ST_OK;
			res.last     = last_s1;
		end
		if (accept) begin
			case (op)
				tsom_pkg::OP_PUSH_X: begin
					res.load = 1'b1;
					res.last = 1'b1;
					if (x_full) begin
						res.status = tsom_pkg::ST_OVERFLOW;
					end else begin
						res.status    = tsom_pkg::ST_OK;
						ram_req.we    = 1'b1;
						ram_req.waddr = tsom_pkg::addr_t'(x_fill_q);
					end
				end
				tsom_pkg::OP_PUSH_Y: begin
					res.load = 1'b1;
					res.last = 1'b1;
					if (y_full) begin
						res.status = tsom_pkg::ST_OVERFLOW;
					end else begin
						res.status    = tsom_pkg::ST_OK;
						ram_req.we    = 1'b1;
						ram_req.waddr = ADDR_LAST - tsom_pkg::addr_t'(y_fill_q);
					end
				end
				tsom_pkg::OP_POP_X: begin
					if (x_empty) begin
						res.load   = 1'b1;
						res.last   = 1'b1;
						res.status = tsom_pkg::ST_UNDERFLOW;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = tsom_pkg::addr_t'(x_fill_q - 1'b1);
					end
				end
				tsom_pkg::OP_POP_Y: begin
					if (y_empty) begin
						res.load   = 1'b1;
						res.last   = 1'b1;
						res.status = tsom_pkg::ST_UNDERFLOW;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = ADDR_LAST - tsom_pkg::addr_t'(y_fill_q - 1'b1);
					end
				end
				tsom_pkg::OP_SHOW_X: begin
					if (x_empty) begin
						res.load   = 1'b1;
						res.last   = 1'b1;
						res.status = tsom_pkg::ST_EMPTY;
					end
				end
				tsom_pkg::OP_SHOW_Y: begin
					if (y_empty) begin
						res.load   = 1'b1;
						res.last   = 1'b1;
						res.status = tsom_pkg::ST_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (show_issue) begin
			ram_req.re    = 1'b1;
			ram_req.raddr = addr_q;
		end
	end

	// fill counts, show walk and read tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			x_fill_q <= '0;
			y_fill_q <= '0;
			cnt_q    <= '0;
			rd_s1    <= 1'b0;
		end else begin
			rd_s1 <= ram_req.re;
			if (accept) begin
				case (op)
					tsom_pkg::OP_PUSH_X: begin
						if (!x_full) x_fill_q <= x_fill_q + 1'b1;
					end
					tsom_pkg::OP_PUSH_Y: begin
						if (!y_full) y_fill_q <= y_fill_q + 1'b1;
					end
					tsom_pkg::OP_POP_X: begin
						if (!x_empty) x_fill_q <= x_fill_q - 1'b1;
					end
					tsom_pkg::OP_POP_Y: begin
						if (!y_empty) y_fill_q <= y_fill_q - 1'b1;
					end
					tsom_pkg::OP_SHOW_X: begin
						if (!x_empty) begin
							state_q <= S_SHOW;
							cnt_q   <= tsom_pkg::cnt_t'(x_fill_q);
						end
					end
					tsom_pkg::OP_SHOW_Y: begin
						if (!y_empty) begin
							state_q <= S_SHOW;
							cnt_q   <= tsom_pkg::cnt_t'(y_fill_q);
						end
					end
					default: begin
					end
				endcase
			end else if (show_issue) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tsom_pkg::cnt_t'(1)) begin
					state_q <= S_IDLE;
				end
			end
		end
	end

	// walk address and last mark of the word in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= 1'b1;
			if (op == tsom_pkg::OP_SHOW_X) begin
				up_q   <= 1'b0;
				addr_q <= tsom_pkg::addr_t'(x_fill_q - 1'b1);
			end else begin
				up_q   <= 1'b1;
				addr_q <= ADDR_LAST - tsom_pkg::addr_t'(y_fill_q - 1'b1);
			end
		end else if (show_issue) begin
			last_s1 <= (cnt_q == tsom_pkg::cnt_t'(1));
			addr_q  <= up_q ? addr_q + 1'b1 : addr_q - 1'b1;
		end
	end

endmodule

>>> tb/tb_two_stacks_one_memory_unit.sv
module tb_two_stacks_one_memory_unit;

	import tsom_pkg::*;

	// opcodes the block takes and answers with nothing
	localparam op_t OP_SPARE_6 = 3'd6;
	localparam op_t OP_SPARE_7 = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 40;
	localparam int PHASES         = 14;
	localparam int PHASE_ITEMS    = 30;

	// phase flavors of the random part
	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_SHOW} phase_mode_t;

	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] word;
		logic             last;
	} stack_result_t;

	// one directed row, repeated rep times; typed rows carry their own answer
	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
		int               rep;
		logic             typed;
		status_t          status;
		logic [VAL_W-1:0] word;
	} plan_row_t;

	// typed answer handed from the driver to the monitor, one per request
	typedef struct packed {
		logic             typed;
		status_t          status;
		logic [VAL_W-1:0] word;
	} typed_answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;  // opcode[2:0], push_value[34:3]
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_W-1:0]   m_tdata;       // status[1:0], word[33:2]
	logic               m_tlast;

	// predictor state
	mem_word_t          shadow_mem [STORE_DEPTH];
	int                 x_count;
	int                 y_count;

	stack_result_t      expected_q [$];
	typed_answer_t      answer_q [$];

	int                 mismatch_count;
	int                 idle_cycles = 0;
	bit                 no_idle;
	int                 results_checked;
	int                 pushes_taken;
	int                 pops_taken;
	int                 shows_taken;
	int                 spare_taken;
	int                 overflow_seen;
	int                 underflow_seen;
	int                 empty_seen;

	two_stacks_one_memory_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatch_count++;
	endtask

	// stored word read back sign-extended to the 32-bit port
	function automatic logic [VAL_W-1:0] stored_to_port(input mem_word_t w);
		logic signed [WORD_WIDTH-1:0] sw;
		logic signed [63:0]           wide;
		sw   = w;
		wide = sw;
		return wide[VAL_W-1:0];
	endfunction

	function automatic mem_word_t port_to_stored(input logic [VAL_W-1:0] v);
		logic signed [63:0] wide;
		wide = $signed(v);
		return wide[WORD_WIDTH-1:0];
	endfunction

	function automatic void queue_result(input status_t st, input logic [VAL_W-1:0] w,
	                                     input logic lst);
		stack_result_t r;
		r.status = st;
		r.word   = w;
		r.last   = lst;
		expected_q.push_back(r);
	endfunction

	// stack behavior: updates the shadow state and queues the expected responses
	function automatic void predict_stacks(input op_t op, input logic [VAL_W-1:0] value);
		case (op)
			OP_PUSH_X: begin
				if (x_count >= X_DEPTH) begin
					queue_result(ST_OVERFLOW, '0, 1'b1);
				end else begin
					shadow_mem[x_count] = port_to_stored(value);
					x_count++;
					queue_result(ST_OK, '0, 1'b1);
				end
			end
			OP_PUSH_Y: begin
				if (y_count >= Y_DEPTH) begin
					queue_result(ST_OVERFLOW, '0, 1'b1);
				end else begin
					shadow_mem[STORE_DEPTH - 1 - y_count] = port_to_stored(value);
					y_count++;
					queue_result(ST_OK, '0, 1'b1);
				end
			end
			OP_POP_X: begin
				if (x_count == 0) begin
					queue_result(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					x_count--;
					queue_result(ST_OK, stored_to_port(shadow_mem[x_count]), 1'b1);
				end
			end
			OP_POP_Y: begin
				if (y_count == 0) begin
					queue_result(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					queue_result(ST_OK, stored_to_port(shadow_mem[STORE_DEPTH - y_count]), 1'b1);
					y_count--;
				end
			end
			OP_SHOW_X: begin
				if (x_count == 0) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = x_count - 1; i >= 0; i--)
						queue_result(ST_OK, stored_to_port(shadow_mem[i]), i == 0);
				end
			end
			OP_SHOW_Y: begin
				if (y_count == 0) begin
					queue_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (int i = STORE_DEPTH - y_count; i < STORE_DEPTH; i++)
						queue_result(ST_OK, stored_to_port(shadow_mem[i]), i == STORE_DEPTH - 1);
				end
			end
			default: begin
			end
		endcase
	endfunction

	// send one request after a random gap, hold it until taken
	task automatic send_request(input op_t op, input logic [VAL_W-1:0] value,
	                            input typed_answer_t answer);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		answer_q.push_back(answer);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_W'({value, op});
		do @(posedge clk); while (!s_tready);
	endtask

	// random push value, extremes now and then
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h7fff_ffff;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic op_t pick_op(input phase_mode_t mode);
		int  r;
		bit  on_y;
		r    = $urandom_range(0, 99);
		on_y = ($urandom_range(0, 1) != 0);
		if (r < 3)
			return ($urandom_range(0, 1) != 0) ? OP_SPARE_7 : OP_SPARE_6;
		case (mode)
			MODE_FILL:  r = (r < 78) ? 0 : (r < 88) ? 1 : 2;
			MODE_DRAIN: r = (r < 18) ? 0 : (r < 88) ? 1 : 2;
			MODE_MIXED: r = (r < 45) ? 0 : (r < 85) ? 1 : 2;
			default:    r = (r < 40) ? 0 : (r < 60) ? 1 : 2;
		endcase
		case (r)
			0:       return on_y ? OP_PUSH_Y : OP_PUSH_X;
			1:       return on_y ? OP_POP_Y : OP_POP_X;
			default: return on_y ? OP_SHOW_Y : OP_SHOW_X;
		endcase
	endfunction

	// result side: random stall before each response, then hold ready until taken
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// monitor: predict on each taken request, check each taken response
	always @(posedge clk) begin
		typed_answer_t ans;
		stack_result_t want;
		int            base;
		op_t           op;
		logic [VAL_W-1:0] value;
		status_t       got_status;
		logic [VAL_W-1:0] got_word;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				op    = s_tdata[OP_W-1:0];
				value = s_tdata[OP_W +: VAL_W];
				ans   = (answer_q.size() != 0) ? answer_q.pop_front() : '0;
				case (op)
					OP_PUSH_X, OP_PUSH_Y: pushes_taken++;
					OP_POP_X, OP_POP_Y:   pops_taken++;
					OP_SHOW_X, OP_SHOW_Y: shows_taken++;
					default:              spare_taken++;
				endcase
				base = expected_q.size();
				predict_stacks(op, value);
				if (ans.typed) begin
					while (expected_q.size() > base)
						void'(expected_q.pop_back());
					queue_result(ans.status, ans.word, 1'b1);
				end
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				got_status = m_tdata[STATUS_W-1:0];
				got_word   = m_tdata[STATUS_W +: VAL_W];
				results_checked++;
				case (got_status)
					ST_OVERFLOW:  overflow_seen++;
					ST_UNDERFLOW: underflow_seen++;
					ST_EMPTY:     empty_seen++;
					default: begin
					end
				endcase
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("response with nothing expected: status %0d word %h",
						got_status, got_word));
				end else begin
					want = expected_q.pop_front();
					if (got_status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d", got_status, want.status));
					if (got_word !== want.word)
						report_mismatch($sformatf("word %h, expected %h", got_word, want.word));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last %b, expected %b", m_tlast, want.last));
				end
			end
			idle_cycles <= moved ? 0 : idle_cycles + 1;
		end
	end

	// watchdog on cycles with no handshake at all
	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("ERROR: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
		$display("tb_two_stacks_one_memory_unit failed");
		$finish;
	end

	// stimulus
	initial begin
		plan_row_t     plan [$];
		typed_answer_t ans;
		phase_mode_t   mode;
		x_count        = 0;
		y_count        = 0;
		mismatch_count = 0;
		no_idle        = 1'b0;
		for (int i = 0; i < STORE_DEPTH; i++)
			shadow_mem[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: empty stacks, extremes, spare opcodes, a full stack
		plan.push_back('{OP_POP_X,   32'h0,          1, 1'b1, ST_UNDERFLOW, 32'h0});
		plan.push_back('{OP_POP_Y,   32'h0,          1, 1'b1, ST_UNDERFLOW, 32'h0});
		plan.push_back('{OP_SHOW_X,  32'h0,          1, 1'b1, ST_EMPTY,     32'h0});
		plan.push_back('{OP_SHOW_Y,  32'h0,          1, 1'b1, ST_EMPTY,     32'h0});
		plan.push_back('{OP_SPARE_6, 32'hffff_ffff,  1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_SPARE_7, 32'h1234_5678,  1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_X,  32'h7fff_ffff,  1, 1'b1, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_X,  32'h8000_0000,  1, 1'b1, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_Y,  32'hffff_ffff,  1, 1'b1, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_Y,  32'h0000_0000,  1, 1'b1, ST_OK,        32'h0});
		plan.push_back('{OP_SHOW_X,  32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_SHOW_Y,  32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_POP_X,   32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_POP_Y,   32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_X,  32'ha5a5_a5a5,  7, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_PUSH_X,  32'h5a5a_5a5a,  1, 1'b1, ST_OVERFLOW,  32'h0});
		plan.push_back('{OP_SHOW_X,  32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_SHOW_Y,  32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_POP_Y,   32'h0,          1, 1'b0, ST_OK,        32'h0});
		plan.push_back('{OP_SHOW_Y,  32'h0,          1, 1'b1, ST_EMPTY,     32'h0});

		foreach (plan[i]) begin
			ans.typed  = plan[i].typed;
			ans.status = plan[i].status;
			ans.word   = plan[i].word;
			repeat (plan[i].rep) send_request(plan[i].op, plan[i].value, ans);
		end

		// random part in phases that fill, drain or mix the stacks
		ans = '0;
		for (int p = 0; p < PHASES; p++) begin
			mode    = phase_mode_t'($urandom_range(0, 3));
			no_idle = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(pick_op(mode), pick_value(), ans);
		end
		no_idle = 1'b0;
		s_tvalid <= 1'b0;
		@(posedge clk);

		// drain, then give stray responses time to show up
		while (expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", expected_q.size()));

		$display("covered %0d pushes, %0d pops, %0d shows, %0d spare opcodes; %0d responses checked",
			pushes_taken, pops_taken, shows_taken, spare_taken, results_checked);
		$display("error answers seen: %0d overflow, %0d underflow, %0d empty; %0d mismatches",
			overflow_seen, underflow_seen, empty_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("tb_two_stacks_one_memory_unit passed");
		end else begin
			$display("tb_two_stacks_one_memory_unit failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/tsom_pkg.sv
rtl/tsom_ram.sv
rtl/tsom_seq.sv
rtl/two_stacks_one_memory_unit.sv
tb/tb_two_stacks_one_memory_unit.sv
